@@ rtl/core/sgrd_pkg.sv @@
`default_nettype none

package sgrd_pkg;

  localparam int PWM_W   = 12;
  localparam int GUARD_W = 10;
  localparam int CFG_W   = 12;
  localparam int IDX_W   = 3;

  localparam logic [PWM_W-1:0] IDLE_LEVEL = PWM_W'(1000);

  localparam logic [IDX_W-1:0] REG_LEVEL_LOW   = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_LEVEL_HIGH_A = IDX_W'(1);
  localparam logic [IDX_W-1:0] REG_LEVEL_HIGH_B = IDX_W'(2);
  localparam logic [IDX_W-1:0] REG_GUARD_TICKS = IDX_W'(3);
  localparam logic [IDX_W-1:0] REG_RAMP_STEP   = IDX_W'(4);

  localparam logic [PWM_W-1:0]   RST_LEVEL_LOW    = PWM_W'(1475);
  localparam logic [PWM_W-1:0]   RST_LEVEL_HIGH_A = PWM_W'(1670);
  localparam logic [PWM_W-1:0]   RST_LEVEL_HIGH_B = PWM_W'(1500);
  localparam logic [GUARD_W-1:0] RST_GUARD_TICKS  = GUARD_W'(600);
  localparam logic [CFG_W-1:0]   RST_RAMP_STEP    = CFG_W'(1);

  localparam logic [1:0] SW_UP  = 2'd1;
  localparam logic [1:0] SW_MID = 2'd3;

  typedef struct packed {
    logic [PWM_W-1:0]   level_low_class;
    logic [PWM_W-1:0]   level_high_a;
    logic [PWM_W-1:0]   level_high_b;
    logic [GUARD_W-1:0] guard_ticks;
    logic [CFG_W-1:0]   ramp_step;
  } cfg_t;

  typedef struct packed {
    logic       limit_high_class;
    logic       ctrl_key;
    logic       shooter_power;
    logic [1:0] switch_pos;
  } in_word_t;

endpackage

`default_nettype wire

@@ rtl/core/sgrd_if.sv @@
`default_nettype none

interface sgrd_in_if;
  logic       valid;
  logic       ready;
  logic       limit_high_class;
  logic       ctrl_key;
  logic       shooter_power;
  logic [1:0] switch_pos;

  modport source (output valid, limit_high_class, ctrl_key, shooter_power, switch_pos,
                  input ready);
  modport sink (input valid, limit_high_class, ctrl_key, shooter_power, switch_pos,
                output ready);
endinterface

interface sgrd_out_if;
  logic                         valid;
  logic                         ready;
  logic [sgrd_pkg::PWM_W-1:0]   pwm_compare;
  logic                         wheels_active;

  modport source (output valid, pwm_compare, wheels_active, input ready);
  modport sink (input valid, pwm_compare, wheels_active, output ready);
endinterface

`default_nettype wire

@@ rtl/core/esc_pwm_soft_start_guard.sv @@
`default_nettype none
// channel  dir  word fields
// in_ch    in   limit_high_class, ctrl_key, shooter_power, switch_pos[1:0]
// out_ch   out  pwm_compare[11:0], wheels_active
// cfg      in   cfg_we, cfg_index[2:0], cfg_data[11:0] (write only)
//
// One word per cycle sustained while out_ch is not stalled; a word's result
// passes through the input register, then the state update loads the output
// register. State and result update in the same edge, so the next word sees
// the new state without a gap.
// Synchronous active-high reset; no clearing pass.
// An output stall holds the result and the input register; in_ch.ready
// stays high while the input register is empty or moving.

module esc_pwm_soft_start_guard (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_we,
  input  wire logic [sgrd_pkg::IDX_W-1:0] cfg_index,
  input  wire logic [sgrd_pkg::CFG_W-1:0] cfg_data,
  sgrd_in_if.sink                         in_ch,
  sgrd_out_if.source                      out_ch
);
  import sgrd_pkg::*;

  cfg_t cfg;

  sgrd_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  sgrd_core u_core (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

endmodule

`default_nettype wire

@@ rtl/core/sgrd_cfg.sv @@
`default_nettype none

module sgrd_cfg (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_we,
  input  wire logic [sgrd_pkg::IDX_W-1:0] cfg_index,
  input  wire logic [sgrd_pkg::CFG_W-1:0] cfg_data,
  output sgrd_pkg::cfg_t                  cfg
);
  import sgrd_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.level_low_class <= RST_LEVEL_LOW;
      cfg.level_high_a    <= RST_LEVEL_HIGH_A;
      cfg.level_high_b    <= RST_LEVEL_HIGH_B;
      cfg.guard_ticks     <= RST_GUARD_TICKS;
      cfg.ramp_step       <= RST_RAMP_STEP;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LEVEL_LOW:    cfg.level_low_class <= cfg_data[PWM_W-1:0];
        REG_LEVEL_HIGH_A: cfg.level_high_a    <= cfg_data[PWM_W-1:0];
        REG_LEVEL_HIGH_B: cfg.level_high_b    <= cfg_data[PWM_W-1:0];
        REG_GUARD_TICKS:  cfg.guard_ticks     <= cfg_data[GUARD_W-1:0];
        REG_RAMP_STEP:    cfg.ramp_step       <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/sgrd_core.sv @@
`default_nettype none

module sgrd_core (
  input  wire logic       clk,
  input  wire logic       rst,
  input  sgrd_pkg::cfg_t  cfg,
  sgrd_in_if.sink         in_ch,
  sgrd_out_if.source      out_ch
);
  import sgrd_pkg::*;

  // input register
  in_word_t s1;
  logic     s1_valid;

  // state
  logic [PWM_W-1:0]   target_level, target_level_next;
  logic               level_armed, level_armed_next;
  logic               ctrl_prev, power_prev;
  logic               off_hold, off_hold_next;
  logic               guard_active, guard_active_next;
  logic               guard_prev;
  logic [GUARD_W-1:0] guard_count, guard_count_next;
  logic [PWM_W-1:0]   ramp_value, ramp_value_next;
  logic               wheels_next;

  logic               advance, step;
  logic               sw_on;
  logic [PWM_W-1:0]   cmd, diff;
  logic [CFG_W-1:0]   delta;

  assign advance     = !out_ch.valid || out_ch.ready;
  assign step        = s1_valid && advance;
  assign in_ch.ready = !s1_valid || advance;

  always_comb begin
    sw_on             = (s1.switch_pos == SW_UP) || (s1.switch_pos == SW_MID);
    target_level_next = target_level;
    level_armed_next  = level_armed;
    guard_count_next  = guard_count;

    if (s1.limit_high_class) begin
      if (!level_armed) begin
        target_level_next = cfg.level_high_a;
        level_armed_next  = 1'b1;
      end
      if (!ctrl_prev && s1.ctrl_key) begin
        target_level_next = (target_level_next == cfg.level_high_a) ?
                            cfg.level_high_b : cfg.level_high_a;
      end
    end else begin
      target_level_next = cfg.level_low_class;
    end

    off_hold_next     = off_hold || (power_prev && !s1.shooter_power);
    guard_active_next = guard_active || (!power_prev && s1.shooter_power);

    if (off_hold_next) target_level_next = IDLE_LEVEL;

    if (guard_active_next) begin
      target_level_next = IDLE_LEVEL;
      off_hold_next     = 1'b0;
      if (guard_count >= cfg.guard_ticks) begin
        guard_count_next  = '0;
        guard_active_next = 1'b0;
      end else begin
        guard_count_next = guard_count + GUARD_W'(1);
      end
    end

    if (guard_prev && !guard_active_next) level_armed_next = 1'b0;

    // ramp toward command, at most ramp_step per tick
    cmd             = sw_on ? target_level_next : IDLE_LEVEL;
    ramp_value_next = ramp_value;
    diff            = '0;
    delta           = '0;
    if (ramp_value < cmd) begin
      diff            = cmd - ramp_value;
      delta           = (cfg.ramp_step < CFG_W'(diff)) ? cfg.ramp_step : CFG_W'(diff);
      ramp_value_next = ramp_value + PWM_W'(delta);
    end else if (ramp_value > cmd) begin
      diff            = ramp_value - cmd;
      delta           = (cfg.ramp_step < CFG_W'(diff)) ? cfg.ramp_step : CFG_W'(diff);
      ramp_value_next = ramp_value - PWM_W'(delta);
    end

    wheels_next = (target_level_next != IDLE_LEVEL) && s1.shooter_power && sw_on;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      out_ch.valid <= 1'b0;
      target_level <= RST_LEVEL_LOW;
      level_armed  <= 1'b0;
      ctrl_prev    <= 1'b0;
      power_prev   <= 1'b0;
      off_hold     <= 1'b0;
      guard_active <= 1'b0;
      guard_prev   <= 1'b0;
      guard_count  <= '0;
      ramp_value   <= IDLE_LEVEL;
    end else begin
      if (in_ch.ready) s1_valid <= in_ch.valid;
      if (advance) out_ch.valid <= s1_valid;
      if (step) begin
        target_level <= target_level_next;
        level_armed  <= level_armed_next;
        ctrl_prev    <= s1.ctrl_key;
        power_prev   <= s1.shooter_power;
        off_hold     <= off_hold_next;
        guard_active <= guard_active_next;
        guard_prev   <= guard_active_next;
        guard_count  <= guard_count_next;
        ramp_value   <= ramp_value_next;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1.limit_high_class <= in_ch.limit_high_class;
      s1.ctrl_key         <= in_ch.ctrl_key;
      s1.shooter_power    <= in_ch.shooter_power;
      s1.switch_pos       <= in_ch.switch_pos;
    end
    if (step) begin
      out_ch.pwm_compare   <= ramp_value_next;
      out_ch.wheels_active <= wheels_next;
    end
  end

  a_guard_idle_count: assert property (@(posedge clk) disable iff (rst)
    !guard_active |-> guard_count == '0)
    else $error("guard count nonzero while guard inactive");

  a_hold_guard_excl: assert property (@(posedge clk) disable iff (rst)
    !(off_hold && guard_active))
    else $error("off hold and guard both set");

  a_step_gives_word: assert property (@(posedge clk) disable iff (rst)
    step |=> out_ch.valid)
    else $error("step produced no output word");

  a_guard_prev_track: assert property (@(posedge clk) disable iff (rst)
    s1_valid && advance |=> guard_prev == guard_active)
    else $error("guard_prev out of step with guard_active");

endmodule

`default_nettype wire
